// ===== hw/rtl/i2cees_pkg.sv =====
package i2cees_pkg;

    localparam logic [1:0] CMD_START_WRITE = 2'd0;
    localparam logic [1:0] CMD_START_READ  = 2'd1;
    localparam logic [1:0] CMD_EVENT       = 2'd2;

    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_READ  = 2'd2;

    localparam logic [7:0] ST_START      = 8'h08;
    localparam logic [7:0] ST_RESTART    = 8'h10;
    localparam logic [7:0] ST_ADDR_W_ACK = 8'h18;
    localparam logic [7:0] ST_DATA_ACK   = 8'h28;
    localparam logic [7:0] ST_ADDR_R_ACK = 8'h40;
    localparam logic [7:0] ST_RX_ACK     = 8'h50;
    localparam logic [7:0] ST_RX_NACK    = 8'h58;

    localparam logic [7:0] COUNT_MAX = 8'hff;

    typedef struct packed {
        logic [1:0]  mode;
        logic        low_address_sent;
        logic [7:0]  device_byte;
        logic [15:0] word_address;
        logic [7:0]  count_wanted;
        logic [7:0]  sent_count;
        logic [7:0]  received_count;
    } state_t;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  dev_address;
        logic [15:0] mem_address;
        logic [7:0]  byte_count;
        logic [7:0]  status_code;
        logic [7:0]  rx_byte;
        logic [7:0]  tx_byte;
    } item_t;

    typedef struct packed {
        logic       load_data;
        logic [7:0] out_byte;
        logic       set_start;
        logic       clear_start;
        logic       set_stop;
        logic       set_ack;
        logic       clear_ack;
        logic       rx_valid;
        logic [7:0] rx_value;
        logic       tx_taken;
        logic       done_res;
    } result_t;

endpackage

// ===== hw/rtl/i2cees_step.sv =====
module i2cees_step (
    input  i2cees_pkg::state_t  state,
    input  i2cees_pkg::item_t   item,
    output i2cees_pkg::result_t result,
    output i2cees_pkg::state_t  state_next
);

    logic [8:0] received_plus_two;

    assign received_plus_two = {1'b0, state.received_count} + 9'd2;

    always_comb begin
        result     = '0;
        state_next = state;
        if (item.cmd == i2cees_pkg::CMD_START_WRITE || item.cmd == i2cees_pkg::CMD_START_READ) begin
            state_next.device_byte      = item.dev_address;
            state_next.word_address     = item.mem_address;
            state_next.count_wanted     = item.byte_count;
            state_next.low_address_sent = 1'b0;
            state_next.sent_count       = '0;
            state_next.received_count   = '0;
            state_next.mode = (item.cmd == i2cees_pkg::CMD_START_WRITE) ?
                              i2cees_pkg::MODE_WRITE : i2cees_pkg::MODE_READ;
            result.set_start = 1'b1;
        end else if (item.cmd == i2cees_pkg::CMD_EVENT) begin
            if (state.mode == i2cees_pkg::MODE_WRITE) begin
                case (item.status_code)
                    i2cees_pkg::ST_START: begin
                        result.load_data   = 1'b1;
                        result.out_byte    = state.device_byte;
                        result.clear_start = 1'b1;
                    end
                    i2cees_pkg::ST_ADDR_W_ACK: begin
                        result.load_data = 1'b1;
                        result.out_byte  = state.word_address[15:8];
                    end
                    i2cees_pkg::ST_DATA_ACK: begin
                        if (!state.low_address_sent) begin
                            result.load_data            = 1'b1;
                            result.out_byte             = state.word_address[7:0];
                            state_next.low_address_sent = 1'b1;
                        end else if (state.sent_count < state.count_wanted) begin
                            result.load_data      = 1'b1;
                            result.out_byte       = item.tx_byte;
                            result.tx_taken       = 1'b1;
                            state_next.sent_count = state.sent_count + 8'd1;
                        end else begin
                            result.set_stop             = 1'b1;
                            result.done_res             = 1'b1;
                            state_next.sent_count       = '0;
                            state_next.low_address_sent = 1'b0;
                            state_next.mode             = i2cees_pkg::MODE_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase
            end else if (state.mode == i2cees_pkg::MODE_READ) begin
                case (item.status_code)
                    i2cees_pkg::ST_START: begin
                        result.load_data   = 1'b1;
                        result.out_byte    = state.device_byte;
                        result.clear_start = 1'b1;
                    end
                    i2cees_pkg::ST_RESTART: begin
                        result.load_data   = 1'b1;
                        result.out_byte    = state.device_byte + 8'd1;
                        result.set_ack     = 1'b1;
                        result.clear_start = 1'b1;
                    end
                    i2cees_pkg::ST_ADDR_W_ACK: begin
                        result.load_data = 1'b1;
                        result.out_byte  = state.word_address[15:8];
                    end
                    i2cees_pkg::ST_DATA_ACK: begin
                        if (!state.low_address_sent) begin
                            result.load_data            = 1'b1;
                            result.out_byte             = state.word_address[7:0];
                            state_next.low_address_sent = 1'b1;
                        end else begin
                            result.set_start = 1'b1;
                        end
                    end
                    i2cees_pkg::ST_ADDR_R_ACK: begin
                        result.clear_ack = (state.count_wanted == 8'd1);
                    end
                    i2cees_pkg::ST_RX_ACK: begin
                        result.rx_valid  = 1'b1;
                        result.rx_value  = item.rx_byte;
                        result.clear_ack = (received_plus_two >= {1'b0, state.count_wanted});
                        if (state.received_count != i2cees_pkg::COUNT_MAX) begin
                            state_next.received_count = state.received_count + 8'd1;
                        end
                    end
                    i2cees_pkg::ST_RX_NACK: begin
                        result.rx_valid             = 1'b1;
                        result.rx_value             = item.rx_byte;
                        result.set_stop             = 1'b1;
                        result.done_res             = 1'b1;
                        state_next.low_address_sent = 1'b0;
                        state_next.received_count   = '0;
                        state_next.mode             = i2cees_pkg::MODE_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/i2c_eeprom_transaction_sequencer.sv =====
// An accepted transaction goes through the input register, then the result register.
// Throughput: one transaction per cycle unless m_ready stalls; the input register and the
// result register let it accept a new transaction while a finished result still waits.
// Reset: aresetn is synchronous and active low; it empties both registers and clears
// the sequencer state to idle with all counts and addresses zero.
module i2c_eeprom_transaction_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_cmd,
    input  logic [7:0]  s_dev_address,
    input  logic [15:0] s_mem_address,
    input  logic [7:0]  s_byte_count,
    input  logic [7:0]  s_status_code,
    input  logic [7:0]  s_rx_byte,
    input  logic [7:0]  s_tx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_load_data,
    output logic [7:0]  m_out_byte,
    output logic        m_set_start,
    output logic        m_clear_start,
    output logic        m_set_stop,
    output logic        m_set_ack,
    output logic        m_clear_ack,
    output logic        m_rx_valid,
    output logic [7:0]  m_rx_value,
    output logic        m_tx_taken,
    output logic        m_done_res
);

    i2cees_pkg::item_t   item_reg;
    logic                item_valid_reg;
    i2cees_pkg::state_t  state_reg;
    i2cees_pkg::state_t  state_next;
    i2cees_pkg::result_t result_reg;
    i2cees_pkg::result_t result_next;
    logic                result_valid_reg;
    logic                result_free;
    logic                advance;

    assign result_free = !result_valid_reg || m_ready;
    assign advance     = item_valid_reg && result_free;
    assign s_ready     = !item_valid_reg || result_free;

    i2cees_step u_step (
        .state      (state_reg),
        .item       (item_reg),
        .result     (result_next),
        .state_next (state_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end else begin
            if (s_ready) begin
                item_valid_reg <= s_valid;
            end
            if (result_free) begin
                result_valid_reg <= item_valid_reg;
            end
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg.cmd         <= s_cmd;
            item_reg.dev_address <= s_dev_address;
            item_reg.mem_address <= s_mem_address;
            item_reg.byte_count  <= s_byte_count;
            item_reg.status_code <= s_status_code;
            item_reg.rx_byte     <= s_rx_byte;
            item_reg.tx_byte     <= s_tx_byte;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    assign m_valid       = result_valid_reg;
    assign m_load_data   = result_reg.load_data;
    assign m_out_byte    = result_reg.out_byte;
    assign m_set_start   = result_reg.set_start;
    assign m_clear_start = result_reg.clear_start;
    assign m_set_stop    = result_reg.set_stop;
    assign m_set_ack     = result_reg.set_ack;
    assign m_clear_ack   = result_reg.clear_ack;
    assign m_rx_valid    = result_reg.rx_valid;
    assign m_rx_value    = result_reg.rx_value;
    assign m_tx_taken    = result_reg.tx_taken;
    assign m_done_res    = result_reg.done_res;

endmodule
